FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file sim_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/sim_pkg.sv
// types, constants and helpers of the sorted interval merge core
// no dependencies
package sim_pkg;

   localparam int MaxIntervals = 64;
   localparam int IdxW = $clog2(MaxIntervals);
   localparam int CntW = $clog2(MaxIntervals + 1);
   localparam int AddrW = 3;
   localparam int RegIdxW = AddrW - 2;
   localparam logic [RegIdxW-1:0] RegMinOverlap = '0;

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
   } span_type;

   typedef struct packed {
      logic     we;
      idx_type  waddr;
      span_type wdata;
      logic     re;
      idx_type  raddr;
   } ram_req_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_KEY_RD,
      ST_KEY_CAP,
      ST_CMP_RD,
      ST_CMP,
      ST_PUT,
      ST_MRG_RD,
      ST_MRG_EVAL,
      ST_FLUSH
   } state_type;

   function automatic logic goes_before(span_type a, span_type b);
      logic r;
      if (a.lo != b.lo) begin
         r = a.lo < b.lo;
      end else begin
         r = a.hi < b.hi;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/sim_ram.sv
// interval store: one write port, one registered read port
// depends on sim_pkg
module sim_ram (
   input  logic                 clock,
   input  sim_pkg::ram_req_type ram_req,
   output sim_pkg::span_type    ram_rdata
);

   sim_pkg::span_type mem [sim_pkg::MaxIntervals];
   sim_pkg::span_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

FILE: rtl/core/sim_seq.sv
// sequencer: loads intervals, insertion sort in memory, merge sweep, result register
// depends on sim_pkg, drives sim_ram
module sim_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_start_pos,
   input  logic [31:0]          req_span_len,
   input  logic                 req_final_item,
   input  logic [31:0]          min_overlap,
   output sim_pkg::ram_req_type ram_req,
   input  sim_pkg::span_type    ram_rdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_out_lo,
   output logic [31:0]          rsp_out_hi,
   output logic [6:0]           rsp_out_count,
   output logic                 rsp_out_last,
   output logic                 rsp_overflowed
);

   sim_pkg::state_type state_ff, state_in;
   sim_pkg::cnt_type   cnt_ff, cnt_in;
   logic               in_order_ff, in_order_in;
   logic               drop_ff, drop_in;
   logic [31:0]        prev_start_ff, prev_start_in;
   sim_pkg::idx_type   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   sim_pkg::span_type  key_ff, key_in, cur_ff, cur_in;
   sim_pkg::cnt_type   cur_cnt_ff, cur_cnt_in;
   logic               rsp_valid_ff;
   sim_pkg::span_type  rsp_span_ff;
   sim_pkg::cnt_type   rsp_cnt_ff;
   logic               rsp_last_ff, rsp_ovf_ff;

   logic               accept, full, store, out_free, in_order_now;
   logic               merge_ok, adv, emit, emit_last;
   logic [32:0]        end_sum, thick_sum;
   sim_pkg::span_type  new_span;
   sim_pkg::cnt_type   n_after;
   sim_pkg::idx_type   last_idx;

   assign req_stall = state_ff != sim_pkg::ST_LOAD;
   assign accept    = req_valid && !req_stall;
   assign full      = cnt_ff == sim_pkg::CntW'(sim_pkg::MaxIntervals);
   assign store     = accept && !full;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_idx  = sim_pkg::IdxW'(cnt_ff - sim_pkg::CntW'(1));
   assign n_after   = store ? cnt_ff + sim_pkg::CntW'(1) : cnt_ff;
   assign in_order_now = in_order_ff && !(store && cnt_ff != '0 && prev_start_ff > req_start_pos);

   assign end_sum    = {1'b0, req_start_pos} + {1'b0, req_span_len};
   assign new_span.lo = req_start_pos;
   assign new_span.hi = end_sum[32] ? '1 : end_sum[31:0];

   // merge test on the word now at the registered read port output
   assign thick_sum = {1'b0, ram_rdata.lo} + {1'b0, min_overlap};
   assign merge_ok  = (cur_ff.lo <= ram_rdata.lo && ram_rdata.hi <= cur_ff.hi)
                      || (thick_sum <= {1'b0, cur_ff.hi});

   always_comb begin
      adv = 1'b0;
      if (state_ff == sim_pkg::ST_MRG_EVAL) begin
         adv = (k_ff == '0) || (cur_ff.lo == '0 && cur_ff.hi == '0) || merge_ok || out_free;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sim_pkg::ST_LOAD: begin
            if (accept && req_final_item) begin
               state_in = (!in_order_now && n_after > sim_pkg::CntW'(1))
                          ? sim_pkg::ST_KEY_RD : sim_pkg::ST_MRG_RD;
            end
         end
         sim_pkg::ST_KEY_RD:  state_in = sim_pkg::ST_KEY_CAP;
         sim_pkg::ST_KEY_CAP: state_in = sim_pkg::ST_CMP_RD;
         sim_pkg::ST_CMP_RD:  state_in = sim_pkg::ST_CMP;
         sim_pkg::ST_CMP: begin
            if (sim_pkg::goes_before(key_ff, ram_rdata) && j_ff != sim_pkg::IdxW'(1)) begin
               state_in = sim_pkg::ST_CMP_RD;
            end else begin
               state_in = sim_pkg::ST_PUT;
            end
         end
         sim_pkg::ST_PUT: begin
            state_in = (i_ff == last_idx) ? sim_pkg::ST_MRG_RD : sim_pkg::ST_KEY_RD;
         end
         sim_pkg::ST_MRG_RD: state_in = sim_pkg::ST_MRG_EVAL;
         sim_pkg::ST_MRG_EVAL: begin
            if (adv) begin
               state_in = (k_ff == last_idx) ? sim_pkg::ST_FLUSH : sim_pkg::ST_MRG_RD;
            end
         end
         sim_pkg::ST_FLUSH: begin
            if (out_free) begin
               state_in = sim_pkg::ST_LOAD;
            end
         end
         default: state_in = sim_pkg::ST_LOAD;
      endcase
   end

   // outputs and datapath
   always_comb begin
      ram_req       = '0;
      cnt_in        = cnt_ff;
      in_order_in   = in_order_ff;
      drop_in       = drop_ff;
      prev_start_in = prev_start_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      cur_cnt_in    = cur_cnt_ff;
      emit          = 1'b0;
      emit_last     = 1'b0;
      unique case (state_ff)
         sim_pkg::ST_LOAD: begin
            if (store) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = sim_pkg::IdxW'(cnt_ff);
               ram_req.wdata = new_span;
               cnt_in        = cnt_ff + sim_pkg::CntW'(1);
               prev_start_in = req_start_pos;
            end
            if (accept && full) begin
               drop_in = 1'b1;
            end
            in_order_in = in_order_now;
            i_in = sim_pkg::IdxW'(1);
            k_in = '0;
         end
         sim_pkg::ST_KEY_RD: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = i_ff;
         end
         sim_pkg::ST_KEY_CAP: begin
            key_in = ram_rdata;
            j_in   = i_ff;
         end
         sim_pkg::ST_CMP_RD: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = j_ff - sim_pkg::IdxW'(1);
         end
         sim_pkg::ST_CMP: begin
            if (sim_pkg::goes_before(key_ff, ram_rdata)) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = j_ff;
               ram_req.wdata = ram_rdata;
               j_in          = j_ff - sim_pkg::IdxW'(1);
            end
         end
         sim_pkg::ST_PUT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = key_ff;
            i_in          = i_ff + sim_pkg::IdxW'(1);
            k_in          = '0;
         end
         sim_pkg::ST_MRG_RD: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = k_ff;
         end
         sim_pkg::ST_MRG_EVAL: begin
            if (k_ff == '0 || (cur_ff.lo == '0 && cur_ff.hi == '0)) begin
               cur_in     = ram_rdata;
               cur_cnt_in = sim_pkg::CntW'(1);
            end else if (merge_ok) begin
               if (cur_ff.hi < ram_rdata.hi) begin
                  cur_in.hi = ram_rdata.hi;
               end
               cur_cnt_in = cur_cnt_ff + sim_pkg::CntW'(1);
            end else if (out_free) begin
               emit       = 1'b1;
               cur_in     = ram_rdata;
               cur_cnt_in = sim_pkg::CntW'(1);
            end
            if (adv) begin
               k_in = k_ff + sim_pkg::IdxW'(1);
            end
         end
         sim_pkg::ST_FLUSH: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_last   = 1'b1;
               cnt_in      = '0;
               in_order_in = 1'b1;
               drop_in     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sim_pkg::ST_LOAD;
         cnt_ff       <= '0;
         in_order_ff  <= 1'b1;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         in_order_ff <= in_order_in;
         drop_ff     <= drop_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_start_ff <= prev_start_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      cur_cnt_ff    <= cur_cnt_in;
      if (emit) begin
         rsp_span_ff <= cur_ff;
         rsp_cnt_ff  <= cur_cnt_ff;
         rsp_last_ff <= emit_last;
         rsp_ovf_ff  <= drop_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_lo     = rsp_span_ff.lo;
   assign rsp_out_hi     = rsp_span_ff.hi;
   assign rsp_out_count  = rsp_cnt_ff;
   assign rsp_out_last   = rsp_last_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

FILE: rtl/core/sorted_interval_merge_core.sv
// top level: register port, interval store and sequencer
// depends on sim_pkg, sim_ram, sim_seq
//
// Intervals arrive one word per cycle while req_stall is low into a 64-entry
// store; a word with final_item set closes the set. If the starts did not
// arrive in order, an insertion sort runs in the store, bound by the single
// registered read port: each interval is read as the key, larger ones left
// of it are moved up one by one, and the key is put in the gap. The merge
// sweep then reads each interval in a read and an evaluate state and emits
// merged intervals through an output register; a flush state sends the
// last. Input is stalled from the final word until the last result word is
// registered. Words beyond 64 are dropped and flagged on every result.
module sorted_interval_merge_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_start_pos,
   input  logic [31:0]                 req_span_len,
   input  logic                        req_final_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [31:0]                 rsp_out_lo,
   output logic [31:0]                 rsp_out_hi,
   output logic [6:0]                  rsp_out_count,
   output logic                        rsp_out_last,
   output logic                        rsp_overflowed,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sim_pkg::AddrW-1:0]   paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [31:0]                 min_overlap_ff;
   logic [sim_pkg::RegIdxW-1:0] reg_idx;
   sim_pkg::ram_req_type        ram_req;
   sim_pkg::span_type           ram_rdata;

   assign pready  = 1'b1;
   assign reg_idx = paddr[sim_pkg::AddrW-1:2];
   assign prdata  = (reg_idx == sim_pkg::RegMinOverlap) ? min_overlap_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_overlap_ff <= '0;
      end else if (psel && penable && pwrite && pready
                   && reg_idx == sim_pkg::RegMinOverlap) begin
         min_overlap_ff <= pwdata;
      end
   end

   sim_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   sim_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_pos  (req_start_pos),
      .req_span_len   (req_span_len),
      .req_final_item (req_final_item),
      .min_overlap    (min_overlap_ff),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_lo     (rsp_out_lo),
      .rsp_out_hi     (rsp_out_hi),
      .rsp_out_count  (rsp_out_count),
      .rsp_out_last   (rsp_out_last),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

FILE: rtl/core/sim_checker.sv
// port-level checks of sorted_interval_merge_core, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module sim_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_lo,
   input logic [31:0] rsp_out_hi,
   input logic [6:0]  rsp_out_count
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result word dropped")
   `CHK_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_lo), "word changed")
   `CHK_IMPLY(a_count_range, clock, reset, rsp_valid, rsp_out_count != 7'd0 && rsp_out_count <= 7'd64, "bad count")
   `CHK_IMPLY(a_span_order, clock, reset, rsp_valid, rsp_out_hi >= rsp_out_lo, "end below start")

endmodule

bind sorted_interval_merge_core sim_checker u_sim_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_lo    (rsp_out_lo),
   .rsp_out_hi    (rsp_out_hi),
   .rsp_out_count (rsp_out_count)
);
